// File: sv/loud_sound_triggered_capture_unit_assert.svh
// ----------------------------------------------------------------------------
// loud_sound_triggered_capture_unit assertion macros
// shared property shapes for the capture unit, clocked on aclk, reset low
// ----------------------------------------------------------------------------
`ifndef LOUD_SOUND_TRIGGERED_CAPTURE_UNIT_ASSERT_SVH
`define LOUD_SOUND_TRIGGERED_CAPTURE_UNIT_ASSERT_SVH

// same-cycle implication
`define LSTC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lstc assertion failed");

// next-cycle implication
`define LSTC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lstc assertion failed");

`endif

// File: sv/lstc_pkg.sv
// ----------------------------------------------------------------------------
// lstc_pkg
// shared widths, defaults, register indexes and result type of the capture unit
// ----------------------------------------------------------------------------
package lstc_pkg;

    localparam int SAMPLE_W      = 12;
    localparam int MAX_CAPTURE   = 1024;
    localparam int LEN_W         = $clog2(MAX_CAPTURE) + 1;
    localparam int IDX_W         = $clog2(MAX_CAPTURE);
    localparam int COUNT_W       = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 12;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 56;

    localparam logic [SAMPLE_W-1:0] MIDPOINT_RST  = SAMPLE_W'(2048);
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = SAMPLE_W'(1000);
    localparam logic [LEN_W-1:0]    LENGTH_RST    = LEN_W'(100 * 3);
    localparam logic [LEN_W-1:0]    MAX_LEN       = LEN_W'(MAX_CAPTURE);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIDPOINT  = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_LENGTH    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] midpoint;
        logic [SAMPLE_W-1:0] loud_threshold;
        logic [LEN_W-1:0]    capture_length;
    } cfg_t;

    typedef struct packed {
        logic [COUNT_W-1:0]  capture_number;
        logic [SAMPLE_W-1:0] peak_deviation;
        logic                capture_done;
        logic [SAMPLE_W-1:0] captured_sample;
        logic [IDX_W-1:0]    stored_index;
        logic                stored_valid;
        logic                capture_started;
        logic                loud_onset;
        logic                loud;
    } result_t;

endpackage

// File: sv/lstc_core.sv
// ----------------------------------------------------------------------------
// lstc_core
// per-sample deviation, level detect and capture state, one sample per enable
// ----------------------------------------------------------------------------
module lstc_core import lstc_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [SAMPLE_W-1:0] sample,
    input  cfg_t                cfg,
    output result_t             result
);

    logic                loud_level_reg,   loud_level_next;
    logic                capturing_reg,    capturing_next;
    logic [LEN_W-1:0]    fill_count_reg,   fill_count_next;
    logic [SAMPLE_W-1:0] running_peak_reg, running_peak_next;
    logic [COUNT_W-1:0]  finished_reg,     finished_next;

    logic [SAMPLE_W-1:0] dev;
    logic                loud, onset, started, active, store, done;
    logic [LEN_W-1:0]    eff_len, fill_base;
    logic [SAMPLE_W-1:0] peak_base;
    logic [COUNT_W-1:0]  finished_inc;

    always_comb begin
        dev          = (sample >= cfg.midpoint) ? (sample - cfg.midpoint)
                                                : (cfg.midpoint - sample);
        loud         = dev > cfg.loud_threshold;
        onset        = loud && !loud_level_reg;
        started      = onset && !capturing_reg;
        active       = capturing_reg || started;
        // a fresh capture starts from an empty buffer and zero peak
        fill_base    = started ? '0 : fill_count_reg;
        peak_base    = started ? '0 : running_peak_reg;
        eff_len      = (cfg.capture_length > MAX_LEN) ? MAX_LEN : cfg.capture_length;
        store        = active && (fill_base < eff_len);
        done         = active && !store;
        finished_inc = finished_reg + COUNT_W'(1);

        loud_level_next   = loud;
        capturing_next    = store;
        fill_count_next   = store ? (fill_base + LEN_W'(1)) : fill_base;
        running_peak_next = (store && (dev > peak_base)) ? dev : peak_base;
        finished_next     = done ? finished_inc : finished_reg;

        result.loud            = loud;
        result.loud_onset      = onset;
        result.capture_started = started;
        result.stored_valid    = store;
        result.stored_index    = store ? fill_base[IDX_W-1:0] : '0;
        result.captured_sample = store ? sample : '0;
        result.capture_done    = done;
        result.peak_deviation  = done ? peak_base : '0;
        result.capture_number  = done ? finished_inc : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loud_level_reg   <= 1'b0;
            capturing_reg    <= 1'b0;
            fill_count_reg   <= '0;
            running_peak_reg <= '0;
            finished_reg     <= '0;
        end else if (step) begin
            loud_level_reg   <= loud_level_next;
            capturing_reg    <= capturing_next;
            fill_count_reg   <= fill_count_next;
            running_peak_reg <= running_peak_next;
            finished_reg     <= finished_next;
        end
    end

endmodule

// File: sv/loud_sound_triggered_capture_unit.sv
// a result word passes through the input register and then the output register
// throughput: one sample word per cycle while m_tready stays high
// back pressure on m_ stalls the output register, then the input register
// reset (aresetn low, synchronous) empties both stages, clears capture state
// and loads the register defaults: midpoint 2048, threshold 1000, length 300
// ----------------------------------------------------------------------------
// loud_sound_triggered_capture_unit
// threshold-triggered sample capture with peak deviation and capture count
// ----------------------------------------------------------------------------
module loud_sound_triggered_capture_unit import lstc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration write port
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // sample input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [11:0] sample, [15:12] zero
    // result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [0] loud, [1] loud_onset,
                                             // [2] capture_started, [3] stored_valid,
                                             // [13:4] stored_index,
                                             // [25:14] captured_sample,
                                             // [26] capture_done,
                                             // [38:27] peak_deviation,
                                             // [54:39] capture_number, [55] zero
);

    `include "loud_sound_triggered_capture_unit_assert.svh"

    // configuration registers
    cfg_t                cfg_reg;

    // input stage
    logic                in_valid_reg, in_valid_next;
    logic [SAMPLE_W-1:0] in_sample_reg;

    // output stage
    logic                out_valid_reg, out_valid_next;
    result_t             out_result_reg;

    result_t             core_result;
    logic                s_accept, advance;

    // the sample stage moves on whenever the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    // register writes; the length register keeps only cfg_wdata[10:0]
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.midpoint       <= MIDPOINT_RST;
            cfg_reg.loud_threshold <= THRESHOLD_RST;
            cfg_reg.capture_length <= LENGTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MIDPOINT:  cfg_reg.midpoint       <= cfg_wdata[SAMPLE_W-1:0];
                REG_THRESHOLD: cfg_reg.loud_threshold <= cfg_wdata[SAMPLE_W-1:0];
                REG_LENGTH:    cfg_reg.capture_length <= cfg_wdata[LEN_W-1:0];
                default:       ;
            endcase
        end
    end

    // control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_sample_reg <= s_tdata[SAMPLE_W-1:0];
        end
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    // deviation, level and capture state; state steps once per sample
    lstc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .sample  (in_sample_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       out_result_reg.capture_number,
                       out_result_reg.peak_deviation,
                       out_result_reg.capture_done,
                       out_result_reg.captured_sample,
                       out_result_reg.stored_index,
                       out_result_reg.stored_valid,
                       out_result_reg.capture_started,
                       out_result_reg.loud_onset,
                       out_result_reg.loud};

    // a sample is either stored or ends the capture, never both
    `LSTC_ASSERT_NOW(a_store_xor_done, aclk, aresetn,
        out_valid_reg, !(out_result_reg.stored_valid && out_result_reg.capture_done))
    // a capture only starts on a loud onset
    `LSTC_ASSERT_NOW(a_start_needs_onset, aclk, aresetn,
        out_valid_reg && out_result_reg.capture_started, out_result_reg.loud_onset)
    // an onset is always loud
    `LSTC_ASSERT_NOW(a_onset_is_loud, aclk, aresetn,
        out_valid_reg && out_result_reg.loud_onset, out_result_reg.loud)
    // a result word is waiting in the output register after every advance
    `LSTC_ASSERT_NEXT(a_result_loads_on_advance, aclk, aresetn,
        advance, out_valid_reg)

endmodule
